>>> rtl/udis_pkg.sv
// Shared types, constants and word formats for the UTF-8 decode and index select block.
package udis_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned CFG_W  = 32;

  // Descriptor queue geometry
  localparam int unsigned DESC_DEPTH = 4;
  localparam int unsigned DESC_PTR_W = $clog2(DESC_DEPTH);

  // Code point constants
  localparam logic [CP_W-1:0]  REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CNT_W-1:0] COUNT_MAX      = 17'h1FFFF;

  // Lead and continuation byte patterns
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_TAG   = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2_BITS  = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_TAG   = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_BITS  = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_TAG   = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_BITS  = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG    = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_BITS   = 8'h3F;

  // Summary status codes
  typedef enum logic [1:0] {
    ST_FOUND         = 2'd0,
    ST_NEGATIVE      = 2'd1,
    ST_OUT_OF_BOUNDS = 2'd2
  } status_e;

  // Result word kinds
  typedef enum logic {
    KIND_CODE_POINT = 1'b0,
    KIND_SUMMARY    = 1'b1
  } kind_e;

  // Input word
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              byte_present;
    logic              is_last;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic             record_kind;
    logic [CP_W-1:0]  code_point;
    logic [IDX_W-1:0] char_index;
    logic             is_selected;
    logic [1:0]       status;
    logic [CNT_W-1:0] cp_total;
    logic             last_result;
  } out_word_t;

  // Work for the back end from one input word: n_cps code points, all
  // replacements except the one at cp_pos when cp_valid, then a summary if set.
  typedef struct packed {
    logic [2:0]      n_cps;
    logic            cp_valid;
    logic [1:0]      cp_pos;
    logic [CP_W-1:0] cp;
    logic            summary;
  } desc_t;

endpackage

>>> rtl/utf8_decode_index_select.sv
// Top level of the UTF-8 decoder with code point index selection.
//
// Input: one string byte per word. Drive in_data_i and raise push; the word
// is taken at a clock edge where full is low. byte_present low with is_last
// high ends an empty string; is_last marks the final byte of a string.
// Output: while empty is low the oldest result word sits on out_data_o; it
// is taken at a clock edge where pop is high. Each code point gives one word
// with its index and a select flag; string end adds a summary word with the
// status and the code point count (last_result set).
// Config: write wanted_index through cfg_valid_i / cfg_data_i; cfg_ready_o
// is always high. Write only while no string is in flight.
// A taken byte's descriptor goes into the queue, and the back end registers
// its first result word onto the outputs. Throughput: one byte per cycle
// while each byte gives at most one result word and pop keeps up; the back
// end emits one result word per cycle unless pop is held low. A four-entry
// descriptor queue absorbs the backlog; full rises once it is filled.
// Reset clears all decode state and sets wanted_index to zero. When the
// receiver stalls, results stay in place, the queue fills, then full rises.
module utf8_decode_index_select import udis_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  in_word_t         in_data_i,
  output logic             empty,
  input  logic             pop,
  output out_word_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  desc_t desc, head;
  logic  desc_valid, accept, head_valid, head_pop;

  // Take a word when the queue has room
  assign accept = push && !full;

  udis_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (in_data_i),
    .accept_i     (accept),
    .desc_o       (desc),
    .desc_valid_o (desc_valid)
  );

  udis_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept && desc_valid),
    .desc_i       (desc),
    .full_o       (full),
    .pop_i        (head_pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  udis_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_data_o   (out_data_o)
  );

endmodule

>>> rtl/udis_front.sv
// Front end: classifies each input byte and turns it into a work descriptor.
module udis_front import udis_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_word_t in_data_i,
  input  logic     accept_i,
  output desc_t    desc_o,
  output logic     desc_valid_o
);

  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] cp;
    logic [1:0]      remaining;
    logic [CP_W-1:0] partial;
  } lead_t;

  // Decode a byte as the start of a code point
  function automatic lead_t decode_lead(input logic [BYTE_W-1:0] b);
    lead_t r;
    r.emit      = 1'b0;
    r.cp        = '0;
    r.remaining = 2'd0;
    r.partial   = '0;
    if (b < ASCII_LIMIT) begin
      r.emit = 1'b1;
      r.cp   = {{(CP_W-BYTE_W){1'b0}}, b};
    end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
      r.partial   = {{(CP_W-BYTE_W){1'b0}}, b & LEAD2_BITS};
      r.remaining = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
      r.partial   = {{(CP_W-BYTE_W){1'b0}}, b & LEAD3_BITS};
      r.remaining = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
      r.partial   = {{(CP_W-BYTE_W){1'b0}}, b & LEAD4_BITS};
      r.remaining = 2'd3;
    end else begin
      r.emit = 1'b1;
      r.cp   = REPLACEMENT_CP;
    end
    return r;
  endfunction

  logic [1:0]        remaining_q, remaining_d;
  logic [1:0]        taken_q, taken_d;
  logic [CP_W-1:0]   partial_q, partial_d;
  lead_t             lead;
  logic              is_cont;
  logic [CP_W-1:0]   extended;
  logic [1:0]        pre_cnt, post_cnt;
  logic              cp_valid;
  logic [CP_W-1:0]   cp_val;
  logic [BYTE_W-1:0] b;

  assign b        = in_data_i.data_byte;
  assign lead     = decode_lead(b);
  assign is_cont  = (b & CONT_MASK) == CONT_TAG;
  assign extended = {partial_q[CP_W-7:0], b[5:0] & CONT_BITS[5:0]};

  // Classify the byte against the pending sequence
  always_comb begin
    remaining_d = remaining_q;
    taken_d     = taken_q;
    partial_d   = partial_q;
    pre_cnt     = 2'd0;
    post_cnt    = 2'd0;
    cp_valid    = 1'b0;
    cp_val      = '0;
    if (in_data_i.byte_present) begin
      if (remaining_q == 2'd0) begin
        cp_valid    = lead.emit;
        cp_val      = lead.cp;
        remaining_d = lead.remaining;
        partial_d   = lead.partial;
        taken_d     = 2'd0;
      end else if (is_cont) begin
        remaining_d = remaining_q - 2'd1;
        if (remaining_q == 2'd1) begin
          cp_valid  = 1'b1;
          cp_val    = extended;
          taken_d   = 2'd0;
          partial_d = '0;
        end else begin
          taken_d   = taken_q + 2'd1;
          partial_d = extended;
        end
      end else begin
        // Replace each byte of the broken sequence, then restart on this byte
        pre_cnt     = taken_q + 2'd1;
        cp_valid    = lead.emit;
        cp_val      = lead.cp;
        remaining_d = lead.remaining;
        partial_d   = lead.partial;
        taken_d     = 2'd0;
      end
    end
    // Flush a cut-off sequence at string end
    if (in_data_i.is_last) begin
      if (remaining_d != 2'd0) begin
        post_cnt = taken_d + 2'd1;
      end
      remaining_d = 2'd0;
      taken_d     = 2'd0;
      partial_d   = '0;
    end
  end

  // Build the descriptor
  always_comb begin
    desc_o.n_cps    = {1'b0, pre_cnt} + {2'b00, cp_valid} + {1'b0, post_cnt};
    desc_o.cp_valid = cp_valid;
    desc_o.cp_pos   = pre_cnt;
    desc_o.cp       = cp_val;
    desc_o.summary  = in_data_i.is_last;
  end

  assign desc_valid_o = (desc_o.n_cps != 3'd0) || in_data_i.is_last;

  // Advance the sequence state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= 2'd0;
      taken_q     <= 2'd0;
      partial_q   <= '0;
    end else if (accept_i) begin
      remaining_q <= remaining_d;
      taken_q     <= taken_d;
      partial_q   <= partial_d;
    end
  end

endmodule

>>> rtl/udis_fifo.sv
// Short descriptor queue between the front end and the back end.
module udis_fifo import udis_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output desc_t head_o,
  output logic  head_valid_o
);

  desc_t                 mem_q [DESC_DEPTH];
  logic [DESC_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [DESC_PTR_W:0]   count_q;
  logic                  do_push, do_pop;

  assign full_o       = count_q == (DESC_PTR_W+1)'(DESC_DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Store pushed descriptors
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + DESC_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + DESC_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (DESC_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (DESC_PTR_W+1)'(1);
      end
    end
  end

endmodule

>>> rtl/udis_back.sv
// Back end: expands descriptors into result words, tracks index, selection and summary.
module udis_back import udis_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  desc_t            head_i,
  input  logic             head_valid_i,
  output logic             head_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output out_word_t        out_data_o
);

  logic signed [CFG_W-1:0] wanted_q;
  logic [2:0]              step_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    found_q;
  logic [CP_W-1:0]         found_cp_q;
  out_word_t               out_q, rec;
  logic                    out_valid_q;
  logic [2:0]              n_items;
  logic                    is_sum, is_last_step, advance, sel;
  logic [CP_W-1:0]         cp_now;
  status_e                 status;

  assign cfg_ready_o = 1'b1;
  assign empty_o     = !out_valid_q;
  assign out_data_o  = out_q;

  // Locate the current step within the head descriptor
  assign n_items      = head_i.n_cps + {2'b00, head_i.summary};
  assign is_sum       = head_i.summary && (step_q == head_i.n_cps);
  assign is_last_step = step_q == (n_items - 3'd1);
  assign advance      = head_valid_i && (!out_valid_q || pop_i);
  assign head_pop_o   = advance && is_last_step;

  // Select and status
  assign sel    = !found_q && !wanted_q[CFG_W-1] &&
                  ($unsigned(wanted_q) == {{(CFG_W-CNT_W){1'b0}}, cnt_q});
  assign cp_now = (head_i.cp_valid && (step_q == {1'b0, head_i.cp_pos})) ?
                  head_i.cp : REPLACEMENT_CP;
  always_comb begin
    if (wanted_q[CFG_W-1]) begin
      status = ST_NEGATIVE;
    end else if (found_q) begin
      status = ST_FOUND;
    end else begin
      status = ST_OUT_OF_BOUNDS;
    end
  end

  // Form the result word for this step
  always_comb begin
    rec = '0;
    if (is_sum) begin
      rec.record_kind = KIND_SUMMARY;
      rec.code_point  = (status == ST_FOUND) ? found_cp_q : '0;
      rec.status      = status;
      rec.cp_total    = cnt_q;
      rec.last_result = 1'b1;
    end else begin
      rec.record_kind = KIND_CODE_POINT;
      rec.code_point  = cp_now;
      rec.char_index  = cnt_q[IDX_W-1:0];
      rec.is_selected = sel;
    end
  end

  // Hold the selected code point
  always_ff @(posedge clk_i) begin
    if (advance && !is_sum && sel) begin
      found_cp_q <= cp_now;
    end
  end

  // Hold the result word
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= rec;
    end
  end

  // Advance step, index and found state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q    <= '0;
      step_q      <= 3'd0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        wanted_q <= cfg_data_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        step_q      <= is_last_step ? 3'd0 : step_q + 3'd1;
        if (is_sum) begin
          cnt_q   <= '0;
          found_q <= 1'b0;
        end else begin
          if (sel) begin
            found_q <= 1'b1;
          end
          if (cnt_q != COUNT_MAX) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // A summary restarts the string count
  a_sum_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_sum |=> cnt_q == '0 && !found_q)
    else $error("count or found not cleared after summary");

  // A selected word marks the string as found
  a_sel_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !is_sum && sel |=> found_q)
    else $error("selection not recorded");

  // Step stays inside the head descriptor
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> step_q < n_items)
    else $error("step beyond descriptor");

  // Step is back at zero when no work is queued
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> step_q == 3'd0)
    else $error("step not reset while idle");

endmodule
